// File: design/mft_pkg.sv
// Shared types, constants and codes of the multi-turn feedback tracker.
`default_nettype none
package mft_pkg;

  localparam int MOTORS    = 2;
  localparam int MOTOR_W   = 1;
  localparam int ID_W      = 11;
  localparam int WORD_W    = 16;
  localparam int TEMP_W    = 8;
  localparam int TOTAL_W   = 30;
  localparam int TURN_SHIFT = 13;
  localparam int JUMP_LIMIT = 6500;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    FUNC_FRAME  = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_REBASE = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ID = 1'd0,
    CFG_WATCHED = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    func_t               func;
    logic [ID_W-1:0]     frame_id;
    logic [MOTOR_W-1:0]  motor_sel;
    logic [WORD_W-1:0]   angle_word;
    logic signed [WORD_W-1:0] speed_word;
    logic signed [WORD_W-1:0] current_word;
    logic [TEMP_W-1:0]   temperature;
  } in_item_t;

  typedef struct packed {
    logic [MOTOR_W-1:0]  motor_index;
    logic                id_error;
    logic [WORD_W-1:0]   angle;
    logic signed [WORD_W-1:0] speed;
    logic signed [WORD_W-1:0] current;
    logic [TEMP_W-1:0]   temp_out;
    logic signed [WORD_W-1:0] turns;
    logic signed [TOTAL_W-1:0] total_angle;
    logic [MOTORS-1:0]   offline_mask;
  } result_t;

endpackage
`default_nettype wire

// File: design/motor_feedback_multiturn_tracker_core.sv
// Top level of the multi-turn motor feedback tracker.
// Tracks up to two motors from feedback frames, check ticks and rebase events and
// returns one result per item. An item passes an input register, the combinational
// per-motor update logic and a result register; m_tvalid rises when the result
// register takes the item's result. One item is accepted every cycle while the output
// side keeps taking results. The single-pass update of the per-motor state (angle,
// turn count, frame counter, offline flag) sets that rate. Configuration writes
// are always taken and must only happen while the block holds no item.
`default_nettype none
module motor_feedback_multiturn_tracker_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // [10:0] frame_id, [11] motor_sel, [27:12] angle_word, [43:28] speed_word,
  // [59:44] current_word, [67:60] temperature, [71:68] zero
  input  wire logic [mft_pkg::IN_TDATA_W-1:0] s_tdata,
  // [1:0] func
  input  wire logic [1:0] s_tuser,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // [15:0] angle, [31:16] speed, [47:32] current, [55:48] temp_out,
  // [71:56] turns, [101:72] total_angle, [103:102] offline_mask
  output logic [mft_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [0] motor_index, [1] id_error
  output logic [1:0] m_tuser,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [mft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mft_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mft_pkg::*;

  logic [ID_W-1:0]   base_id;
  logic [MOTORS-1:0] watched_mask;
  in_item_t          in_item;
  in_item_t          item;
  logic              item_valid;
  logic              take;
  result_t           res;
  result_t           out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id      <= ID_W'(517);
      watched_mask <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BASE_ID: base_id      <= cfg_data[ID_W-1:0];
        CFG_WATCHED: watched_mask <= cfg_data[MOTORS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.func         = func_t'(s_tuser);
    in_item.frame_id     = s_tdata[10:0];
    in_item.motor_sel    = s_tdata[11];
    in_item.angle_word   = s_tdata[27:12];
    in_item.speed_word   = s_tdata[43:28];
    in_item.current_word = s_tdata[59:44];
    in_item.temperature  = s_tdata[67:60];
  end

  mft_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  mft_tracker u_trk (
    .clk          (clk),
    .rst          (rst),
    .step         (item_valid && take),
    .item         (item),
    .base_id      (base_id),
    .watched_mask (watched_mask),
    .result       (res)
  );

  mft_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (item_valid),
    .res_ready (take),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tuser = {out_res.id_error, out_res.motor_index};
  assign m_tdata = {out_res.offline_mask, out_res.total_angle, out_res.turns,
                    out_res.temp_out, out_res.current, out_res.speed, out_res.angle};

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  a_id_error_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[101:0] == '0 && m_tuser[0] == 1'b0)
    else $error("identifier error result carries data");

  a_total_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[101:72] ==
      30'({14'b0, m_tdata[15:0]}) + 30'({m_tdata[71], m_tdata[71:56], 13'b0}))
    else $error("total angle disagrees with angle and turns");

  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    item_valid && take |=> m_tvalid)
    else $error("item lost between update and result register");
endmodule
`default_nettype wire

// File: design/mft_in_stage.sv
// Input register: holds one accepted item until the update stage takes it.
`default_nettype none
module mft_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mft_pkg::in_item_t in_item,
  input  wire logic             take,
  output logic                  item_valid,
  output mft_pkg::in_item_t     item
);
  import mft_pkg::*;

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end
endmodule
`default_nettype wire

// File: design/mft_tracker.sv
// Per-motor state and the single-pass update that forms one result per item.
`default_nettype none
module mft_tracker (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire mft_pkg::in_item_t      item,
  input  wire logic [mft_pkg::ID_W-1:0]   base_id,
  input  wire logic [mft_pkg::MOTORS-1:0] watched_mask,
  output mft_pkg::result_t            result
);
  import mft_pkg::*;

  logic [WORD_W-1:0]        prev_angle [MOTORS];
  logic [WORD_W-1:0]        now_angle  [MOTORS];
  logic signed [WORD_W-1:0] turn_count [MOTORS];
  logic [7:0]               frames_seen [MOTORS];
  logic [MOTORS-1:0]        offline_flags;

  logic [WORD_W-1:0]        prev_angle_next [MOTORS];
  logic [WORD_W-1:0]        now_angle_next  [MOTORS];
  logic signed [WORD_W-1:0] turn_count_next [MOTORS];
  logic [7:0]               frames_seen_next [MOTORS];
  logic [MOTORS-1:0]        offline_flags_next;

  logic [ID_W:0]            id_diff;
  logic                     id_hit;
  logic [MOTOR_W-1:0]       idx;
  logic signed [WORD_W:0]   delta;
  logic signed [WORD_W-1:0] t;
  logic                     wrap_up;
  logic                     wrap_down;

  always_comb begin
    id_diff = {1'b0, item.frame_id} - {1'b0, base_id};
    id_hit  = id_diff < (ID_W+1)'(MOTORS);
    idx     = id_diff[MOTOR_W-1:0];
    delta   = signed'({1'b0, item.angle_word}) - signed'({1'b0, now_angle[idx]});
    wrap_up   = delta < -(WORD_W+1)'(JUMP_LIMIT);
    wrap_down = delta > (WORD_W+1)'(JUMP_LIMIT);
    t = turn_count[idx];
    if (wrap_up && t != 16'sh7FFF) begin
      t = t + 16'sd1;
    end
    if (wrap_down && t != -16'sh8000) begin
      t = t - 16'sd1;
    end

    prev_angle_next    = prev_angle;
    now_angle_next     = now_angle;
    turn_count_next    = turn_count;
    frames_seen_next   = frames_seen;
    offline_flags_next = offline_flags;
    result             = '0;

    unique case (item.func)
      FUNC_FRAME: begin
        if (!id_hit) begin
          result.id_error = 1'b1;
        end else begin
          prev_angle_next[idx] = now_angle[idx];
          now_angle_next[idx]  = item.angle_word;
          turn_count_next[idx] = t;
          if (frames_seen[idx] != 8'hFF) begin
            frames_seen_next[idx] = frames_seen[idx] + 8'd1;
          end
          result.motor_index = idx;
          result.angle       = item.angle_word;
          result.speed       = item.speed_word;
          result.current     = item.current_word;
          result.temp_out    = item.temperature;
          result.turns       = t;
          result.total_angle = signed'({{(TOTAL_W-WORD_W){1'b0}}, item.angle_word})
                             + signed'({t[WORD_W-1], t, {TURN_SHIFT{1'b0}}});
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < MOTORS; i++) begin
          if (watched_mask[i]) begin
            offline_flags_next[i] = (frames_seen[i] == 8'd0);
            frames_seen_next[i]   = 8'd0;
          end
        end
      end
      FUNC_REBASE: begin
        prev_angle_next[item.motor_sel] = now_angle[item.motor_sel];
        turn_count_next[item.motor_sel] = '0;
        result.motor_index = item.motor_sel;
        result.angle       = now_angle[item.motor_sel];
        result.total_angle = signed'({{(TOTAL_W-WORD_W){1'b0}}, now_angle[item.motor_sel]});
      end
      default: begin
      end
    endcase

    result.offline_mask = offline_flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        prev_angle[i]  <= '0;
        now_angle[i]   <= '0;
        turn_count[i]  <= '0;
        frames_seen[i] <= '0;
      end
      offline_flags <= '0;
    end else if (step) begin
      prev_angle    <= prev_angle_next;
      now_angle     <= now_angle_next;
      turn_count    <= turn_count_next;
      frames_seen   <= frames_seen_next;
      offline_flags <= offline_flags_next;
    end
  end
endmodule
`default_nettype wire

// File: design/mft_out_stage.sv
// Result register: holds one result until the downstream side takes it.
`default_nettype none
module mft_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  output logic                   res_ready,
  input  wire mft_pkg::result_t  res,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mft_pkg::result_t       out_res
);
  import mft_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end
endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the multi-turn motor feedback tracker core.
module testbench;
  import mft_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  wire s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  wire m_tvalid;
  logic m_tready = 1'b0;
  wire [OUT_TDATA_W-1:0] m_tdata;
  wire [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  wire cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  motor_feedback_multiturn_tracker_core uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // tracker state as predicted
  logic [ID_W-1:0] id_base = 11'd517;
  logic [1:0] watch_bits = 2'b11;
  logic [WORD_W-1:0] last_angle [MOTORS];
  logic [WORD_W-1:0] cur_angle [MOTORS];
  logic signed [WORD_W-1:0] turn_cnt [MOTORS];
  logic [7:0] seen_cnt [MOTORS];
  logic [MOTORS-1:0] stale = '0;

  result_t pending_results [$];
  int mismatches = 0;
  int gap_max = 0;
  int burst_left = 0;
  int stall_max = 0;
  int rx_left = 0;
  bit rx_on = 1'b1;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t track_item(in_item_t it);
    result_t r;
    int idx;
    int new_a;
    int old_a;
    int t;
    r = '0;
    case (it.func)
      FUNC_FRAME: begin
        idx = int'(it.frame_id) - int'(id_base);
        if (idx < 0 || idx >= MOTORS) begin
          r.id_error = 1'b1;
        end else begin
          last_angle[idx] = cur_angle[idx];
          cur_angle[idx] = it.angle_word;
          new_a = int'(cur_angle[idx]);
          old_a = int'(last_angle[idx]);
          t = int'(turn_cnt[idx]);
          if (new_a - old_a < -JUMP_LIMIT && t < 32767) t++;
          if (old_a - new_a < -JUMP_LIMIT && t > -32768) t--;
          turn_cnt[idx] = WORD_W'(t);
          if (seen_cnt[idx] != 8'hFF) seen_cnt[idx]++;
          r.motor_index = MOTOR_W'(idx);
          r.angle = cur_angle[idx];
          r.speed = it.speed_word;
          r.current = it.current_word;
          r.temp_out = it.temperature;
          r.turns = turn_cnt[idx];
          r.total_angle = TOTAL_W'(new_a + t * (1 << TURN_SHIFT));
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < MOTORS; i++) begin
          if (watch_bits[i]) begin
            stale[i] = (seen_cnt[i] == 8'd0);
            seen_cnt[i] = 8'd0;
          end
        end
      end
      FUNC_REBASE: begin
        idx = int'(it.motor_sel);
        if (idx < MOTORS) begin
          last_angle[idx] = cur_angle[idx];
          turn_cnt[idx] = '0;
          r.motor_index = it.motor_sel;
          r.angle = cur_angle[idx];
          r.total_angle = TOTAL_W'(int'(cur_angle[idx]));
        end
      end
      default: ;
    endcase
    r.offline_mask = stale;
    return r;
  endfunction

  function automatic in_item_t frame_item(int id, int ang, int spd, int cur, int tmp);
    in_item_t it;
    it = '0;
    it.func = FUNC_FRAME;
    it.frame_id = ID_W'(id);
    it.motor_sel = MOTOR_W'($urandom_range(1));
    it.angle_word = WORD_W'(ang);
    it.speed_word = WORD_W'(spd);
    it.current_word = WORD_W'(cur);
    it.temperature = TEMP_W'(tmp);
    return it;
  endfunction

  function automatic in_item_t ctrl_item(func_t f, int sel);
    in_item_t it;
    it = frame_item($urandom, $urandom, $urandom, $urandom, $urandom);
    it.func = f;
    it.motor_sel = MOTOR_W'(sel);
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int k;
    int m;
    int delta;
    bit near;
    it = frame_item($urandom, $urandom, $urandom, $urandom, $urandom);
    k = $urandom_range(99);
    if (k < 72) it.func = FUNC_FRAME;
    else if (k < 84) it.func = FUNC_TICK;
    else if (k < 95) it.func = FUNC_REBASE;
    else it.func = FUNC_RSVD;
    if ($urandom_range(4) != 0) it.frame_id = id_base + ID_W'($urandom_range(1));
    m = int'(it.frame_id) - int'(id_base);
    if (m < 0 || m >= MOTORS) m = $urandom_range(MOTORS - 1);
    near = 1'b1;
    case ($urandom_range(9))
      0, 1, 2: near = 1'b0;
      3: delta = 6500;
      4: delta = -6500;
      5: delta = 6501;
      6: delta = -6501;
      default: delta = int'($urandom_range(6000)) - 3000;
    endcase
    if (near) it.angle_word = cur_angle[m] + WORD_W'(delta);
    return it;
  endfunction

  // next angle: turn count one step up (gain) or down, or no step near an end
  function automatic int spin_angle(int cur, bit gain);
    if (gain)
      return (cur >= 7001) ? cur - 6501 - int'($urandom_range(500))
                           : cur + int'($urandom_range(4000, 6500));
    return (cur <= 58534) ? cur + 6501 + int'($urandom_range(500))
                          : cur - int'($urandom_range(4000, 6500));
  endfunction

  task automatic set_pace(int gaps, int stalls);
    gap_max = gaps;
    stall_max = stalls;
  endtask

  task automatic push_item(in_item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) gap = $urandom_range(1, gap_max);
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.func;
    s_tdata <= {4'b0, it.temperature, it.current_word, it.speed_word, it.angle_word,
                it.motor_sel, it.frame_id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(track_item(it));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BASE_ID: id_base = val;
      CFG_WATCHED: watch_bits = val[1:0];
      default: ;
    endcase
  endtask

  task automatic flag_bad(string what, longint want_v, longint got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : check_result
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '0;
      got.motor_index = m_tuser[0];
      got.id_error = m_tuser[1];
      got.angle = m_tdata[15:0];
      got.speed = m_tdata[31:16];
      got.current = m_tdata[47:32];
      got.temp_out = m_tdata[55:48];
      got.turns = m_tdata[71:56];
      got.total_angle = m_tdata[101:72];
      got.offline_mask = m_tdata[103:102];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no item pending, tdata %h", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (want.motor_index !== got.motor_index)
          flag_bad("motor_index", want.motor_index, got.motor_index);
        if (want.id_error !== got.id_error) flag_bad("id_error", want.id_error, got.id_error);
        if (want.angle !== got.angle) flag_bad("angle", want.angle, got.angle);
        if (want.speed !== got.speed) flag_bad("speed", want.speed, got.speed);
        if (want.current !== got.current) flag_bad("current", want.current, got.current);
        if (want.temp_out !== got.temp_out) flag_bad("temp_out", want.temp_out, got.temp_out);
        if (want.turns !== got.turns) flag_bad("turns", want.turns, got.turns);
        if (want.total_angle !== got.total_angle)
          flag_bad("total_angle", want.total_angle, got.total_angle);
        if (want.offline_mask !== got.offline_mask)
          flag_bad("offline_mask", want.offline_mask, got.offline_mask);
      end
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_on = (stall_max == 0) || ($urandom_range(2) != 0);
      rx_left = rx_on ? $urandom_range(1, 16) : $urandom_range(1, stall_max);
    end
    rx_left--;
    m_tready <= rx_on;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL motor_feedback_multiturn_tracker_core");
      $finish;
    end
  end

  // reset config: small jumps, exact thresholds, wraps, bad ids, ticks, rebases
  task automatic test_directed_basics();
    in_item_t it;
    set_pace(3, 4);
    push_item(frame_item(517, 0, 32767, -32768, 255));
    push_item(frame_item(517, 6500, -32768, 32767, 0));
    push_item(frame_item(517, 13001, 0, 0, 128));
    push_item(frame_item(517, 6500, -1, 1, 1));
    push_item(frame_item(517, 0, 0, 0, 0));
    push_item(frame_item(517, 65535, 1, -1, 254));
    push_item(frame_item(517, 0, 32767, 32767, 255));
    push_item(frame_item(518, 65535, -32768, -32768, 127));
    push_item(frame_item(516, 1234, 5, 6, 7));
    push_item(frame_item(519, 4321, 8, 9, 10));
    push_item(frame_item(0, 65535, -1, -1, 255));
    push_item(frame_item(2047, 65535, -1, -1, 255));
    push_item(ctrl_item(FUNC_TICK, 0));
    push_item(ctrl_item(FUNC_TICK, 1));
    push_item(frame_item(518, 100, 11, 12, 13));
    push_item(ctrl_item(FUNC_TICK, 0));
    push_item(ctrl_item(FUNC_REBASE, 0));
    push_item(ctrl_item(FUNC_REBASE, 1));
    push_item(ctrl_item(FUNC_RSVD, 1));
    it = ctrl_item(FUNC_RSVD, 0);
    it.frame_id = 11'd517;
    push_item(it);
    drain();
  endtask

  task automatic test_config_regs();
    set_pace(2, 3);
    write_reg(CFG_BASE_ID, 11'd0);
    write_reg(CFG_WATCHED, 11'd0);
    push_item(frame_item(0, 30000, 1, 2, 3));
    push_item(frame_item(1, 40000, 4, 5, 6));
    push_item(frame_item(2, 1, 1, 1, 1));
    push_item(ctrl_item(FUNC_TICK, 0));
    write_reg(CFG_WATCHED, 11'h7FD);
    push_item(ctrl_item(FUNC_TICK, 1));
    push_item(ctrl_item(FUNC_TICK, 0));
    write_reg(CFG_BASE_ID, 11'd2047);
    push_item(frame_item(2047, 50000, 7, 8, 9));
    push_item(frame_item(2046, 2, 2, 2, 2));
    push_item(frame_item(0, 3, 3, 3, 3));
    write_reg(CFG_BASE_ID, 11'd2046);
    push_item(frame_item(2047, 60000, 10, 11, 12));
    push_item(frame_item(2046, 100, 13, 14, 15));
    push_item(frame_item(2045, 4, 4, 4, 4));
    write_reg(CFG_WATCHED, 11'h7FE);
    push_item(ctrl_item(FUNC_TICK, 0));
    push_item(ctrl_item(FUNC_TICK, 1));
    write_reg(CFG_WATCHED, 11'd3);
    push_item(ctrl_item(FUNC_TICK, 0));
    drain();
  endtask

  // frame counter must hold at its top value, not wrap back to zero
  task automatic test_frame_counter();
    set_pace(4, 6);
    write_reg(CFG_BASE_ID, 11'd300);
    write_reg(CFG_WATCHED, 11'd3);
    push_item(ctrl_item(FUNC_TICK, 0));
    for (int n = 0; n < 256; n++)
      push_item(frame_item(300, int'(cur_angle[0]) + int'($urandom_range(200)) - 100,
                           $urandom, $urandom, $urandom));
    push_item(ctrl_item(FUNC_TICK, 1));
    drain();
  endtask

  // runs of wraps in both directions, angle extremes, rebase in between
  task automatic test_turn_wraps();
    set_pace(0, 0);
    write_reg(CFG_BASE_ID, 11'd1234);
    push_item(ctrl_item(FUNC_REBASE, 1));
    for (int n = 0; n < 40; n++)
      push_item(frame_item(1235, spin_angle(cur_angle[1], 1'b1), $urandom, $urandom, $urandom));
    while (cur_angle[1] != 16'hFFFF)
      push_item(frame_item(1235, (int'(cur_angle[1]) > 59035) ? 65535 : int'(cur_angle[1]) + 6500,
                           $urandom, $urandom, $urandom));
    push_item(frame_item(1235, 59000, $urandom, $urandom, $urandom));
    push_item(ctrl_item(FUNC_TICK, 0));
    push_item(ctrl_item(FUNC_REBASE, 1));
    for (int n = 0; n < 40; n++)
      push_item(frame_item(1235, spin_angle(cur_angle[1], 1'b0), $urandom, $urandom, $urandom));
    while (cur_angle[1] != 16'h0000)
      push_item(frame_item(1235, (int'(cur_angle[1]) < 6500) ? 0 : int'(cur_angle[1]) - 6500,
                           $urandom, $urandom, $urandom));
    push_item(frame_item(1235, 6600, $urandom, $urandom, $urandom));
    push_item(ctrl_item(FUNC_REBASE, 1));
    drain();
  endtask

  task automatic test_random_traffic();
    logic [ID_W-1:0] base_pick;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: base_pick = 11'd517;
        1: base_pick = 11'd0;
        2: base_pick = 11'd2047;
        4: base_pick = 11'd2046;
        default: base_pick = ID_W'($urandom);
      endcase
      write_reg(CFG_BASE_ID, base_pick);
      write_reg(CFG_WATCHED, (phase == 1) ? 11'd0 : (phase == 2) ? 11'd3
                                          : CFG_DATA_W'($urandom));
      if (phase == 0) set_pace(0, 0);
      else set_pace($urandom_range(1, 8), $urandom_range(1, 10));
      for (int n = 0; n < 200; n++) begin
        push_item(rand_item());
        if (n == 99) drain();
      end
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < MOTORS; i++) begin
      last_angle[i] = '0;
      cur_angle[i] = '0;
      turn_cnt[i] = '0;
      seen_cnt[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_basics();
    test_config_regs();
    test_frame_counter();
    test_turn_wraps();
    test_random_traffic();
    drain();
    if (mismatches == 0) begin
      $display("PASS motor_feedback_multiturn_tracker_core");
    end else begin
      $display("FAIL motor_feedback_multiturn_tracker_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/mft_pkg.sv
design/mft_in_stage.sv
design/mft_tracker.sv
design/mft_out_stage.sv
design/motor_feedback_multiturn_tracker_core.sv
sim/testbench.sv
